### sv/rsa_pkg.sv
// rsa_pkg: shared widths, register codes and item types for the rational
// approximation search block
// no dependencies
`timescale 1ns / 1ps

package rsa_pkg;

    // field widths
    localparam int INT_W       = 32;
    localparam int FRAC_W      = 32;
    localparam int ERR_W       = 32;
    localparam int LIMIT_W     = 16;
    localparam int DEN_W       = 32;
    localparam int NUM_W       = INT_W + DEN_W;
    localparam int PROD_W      = FRAC_W + DEN_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register reset values
    localparam logic [ERR_W-1:0]   ERR_RESET   = '0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOLERANCE  = 1'b0,
        REG_ITER_LIMIT = 1'b1
    } t_cfg_reg;

    // classified item as held in the queue
    typedef struct packed {
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac;
        logic              zero_frac;
    } t_item;

    // head of the queue as seen by the back part
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // a search bound n/d with f*d and e*d kept alongside
    typedef struct packed {
        logic [DEN_W-1:0]  n;
        logic [DEN_W-1:0]  d;
        logic [PROD_W-1:0] fd;
        logic [PROD_W-1:0] ed;
    } t_bound;

    // a mediant, one bit wider so that denominator overflow shows
    typedef struct packed {
        logic [DEN_W:0]    n;
        logic [DEN_W:0]    d;
        logic [PROD_W-1:0] fd;
        logic [PROD_W-1:0] ed;
    } t_mediant;

endpackage

### sv/rsa_front.sv
// rsa_front: accepts input items, flags a zero fraction and holds them in
// a two-entry queue for the search engine
// depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [rsa_pkg::INT_W-1:0]  i_value_int,
    input  logic [rsa_pkg::FRAC_W-1:0] i_value_frac,
    input  logic                       i_pop,
    output rsa_pkg::t_head             o_head
);
    import rsa_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic               push;
    logic               pop;
    t_item              new_item;

    // classify the incoming item
    always_comb begin
        new_item.int_part  = i_value_int;
        new_item.frac      = i_value_frac;
        new_item.zero_frac = (i_value_frac == '0);
    end

    assign o_in_stall = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];

endmodule

### sv/rsa_back.sv
// rsa_back: stern-brocot mediant search, one mediant per cycle, then the
// numerator fix-up and the output register
// depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsa_pkg::t_head              i_head,
    output logic                        o_pop,
    input  logic [rsa_pkg::ERR_W-1:0]   i_tolerance,
    input  logic [rsa_pkg::LIMIT_W-1:0] i_iter_limit,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [rsa_pkg::NUM_W-1:0]   o_numerator,
    output logic [rsa_pkg::DEN_W-1:0]   o_denominator
);
    import rsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [INT_W-1:0]    r_int_part;
    logic [LIMIT_W-1:0]  r_steps;
    t_bound              r_lo;
    t_bound              r_hi;
    t_mediant            r_med;
    logic                r_res_found;
    logic [NUM_W-1:0]    r_res_num;
    logic [DEN_W-1:0]    r_res_den;
    logic [DEN_W-1:0]    r_res_n;
    logic                r_out_valid;
    logic                r_found;
    logic [NUM_W-1:0]    r_numerator;
    logic [DEN_W-1:0]    r_denominator;

    logic [PROD_W-1:0]   scaled_n;
    logic [PROD_W-1:0]   diff_ab;
    logic [PROD_W-1:0]   diff_ba;
    logic                above;
    logic                close;
    logic                give_up;
    t_bound              med_bound;
    t_mediant            n_med_lo;
    t_mediant            n_med_hi;
    logic [PROD_W-1:0]   f_ext;
    logic [PROD_W-1:0]   e_ext;
    logic [NUM_W-1:0]    prod;
    logic                out_free;

    // exact compare of n/d against f: |n*2^F - f*d| <= e*d
    always_comb begin
        scaled_n = {r_med.n[DEN_W-1:0], {FRAC_W{1'b0}}};
        above    = (scaled_n < r_med.fd);
        diff_ab  = scaled_n - r_med.fd;
        diff_ba  = r_med.fd - scaled_n;
        close    = above ? (diff_ba <= r_med.ed) : (diff_ab <= r_med.ed);
        give_up  = (r_steps == i_iter_limit) || r_med.d[DEN_W];
    end

    // both candidate next mediants, picked by the compare
    always_comb begin
        med_bound.n  = r_med.n[DEN_W-1:0];
        med_bound.d  = r_med.d[DEN_W-1:0];
        med_bound.fd = r_med.fd;
        med_bound.ed = r_med.ed;

        n_med_lo.n  = {1'b0, med_bound.n} + {1'b0, r_hi.n};
        n_med_lo.d  = {1'b0, med_bound.d} + {1'b0, r_hi.d};
        n_med_lo.fd = med_bound.fd + r_hi.fd;
        n_med_lo.ed = med_bound.ed + r_hi.ed;

        n_med_hi.n  = {1'b0, r_lo.n} + {1'b0, med_bound.n};
        n_med_hi.d  = {1'b0, r_lo.d} + {1'b0, med_bound.d};
        n_med_hi.fd = r_lo.fd + med_bound.fd;
        n_med_hi.ed = r_lo.ed + med_bound.ed;
    end

    assign f_ext    = PROD_W'(i_head.item.frac);
    assign e_ext    = PROD_W'(i_tolerance);
    assign prod     = NUM_W'(r_int_part) * NUM_W'(r_res_den);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    // search sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
        end else begin
            // output handshake: load a new result or drop an accepted one
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_int_part <= i_head.item.int_part;
                        r_steps    <= '0;
                        r_lo.n     <= '0;
                        r_lo.d     <= DEN_W'(1);
                        r_lo.fd    <= f_ext;
                        r_lo.ed    <= e_ext;
                        r_hi.n     <= DEN_W'(1);
                        r_hi.d     <= DEN_W'(1);
                        r_hi.fd    <= f_ext;
                        r_hi.ed    <= e_ext;
                        r_med.n    <= (DEN_W+1)'(1);
                        r_med.d    <= (DEN_W+1)'(2);
                        r_med.fd   <= f_ext << 1;
                        r_med.ed   <= e_ext << 1;
                        if (i_head.item.zero_frac) begin
                            // integer value: answer is value/1
                            r_res_found <= 1'b1;
                            r_res_num   <= NUM_W'(i_head.item.int_part);
                            r_res_den   <= DEN_W'(1);
                            r_state     <= S_DONE;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (give_up) begin
                        r_res_found <= 1'b0;
                        r_res_num   <= '0;
                        r_res_den   <= '0;
                        r_state     <= S_DONE;
                    end else if (close) begin
                        r_res_den <= med_bound.d;
                        r_res_n   <= med_bound.n;
                        r_state   <= S_MUL;
                    end else begin
                        r_steps <= r_steps + 1'b1;
                        if (above) begin
                            r_lo  <= med_bound;
                            r_med <= n_med_lo;
                        end else begin
                            r_hi  <= med_bound;
                            r_med <= n_med_hi;
                        end
                    end
                end
                S_MUL: begin
                    r_res_num <= prod;
                    r_state   <= S_ADD;
                end
                S_ADD: begin
                    r_res_num   <= r_res_num + NUM_W'(r_res_n);
                    r_res_found <= 1'b1;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_found       <= r_res_found;
                        r_numerator   <= r_res_num;
                        r_denominator <= r_res_den;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_numerator   = r_numerator;
    assign o_denominator = r_denominator;

endmodule

### sv/rational_approximation_search.sv
// rational_approximation_search: top level with configuration registers,
// the input queue front and the mediant search back
// depends on rsa_pkg, rsa_front, rsa_back
// an integer value goes from idle straight to the output register; a value
// found after k mediants then takes a multiply and an add; a value not found
// ends when the limit L is spent (or earlier on denominator overflow)
// the search engine takes one mediant per cycle and one item at a time, and
// a two-entry queue takes items while the engine is busy
// synchronous active-low reset: queue empty, no result, tolerance 0,
// iteration_limit 1000
`timescale 1ns / 1ps

module rational_approximation_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rsa_pkg::INT_W-1:0]      i_value_int,
    input  logic [rsa_pkg::FRAC_W-1:0]     i_value_frac,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_found,
    output logic [rsa_pkg::NUM_W-1:0]      o_numerator,
    output logic [rsa_pkg::DEN_W-1:0]      o_denominator
);
    import rsa_pkg::*;

    logic [ERR_W-1:0]   r_tolerance;
    logic [LIMIT_W-1:0] r_iter_limit;
    t_head              head;
    logic               pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance  <= ERR_RESET;
            r_iter_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TOLERANCE:  r_tolerance  <= i_cfg_data[ERR_W-1:0];
                REG_ITER_LIMIT: r_iter_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input queue
    rsa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value_int  (i_value_int),
        .i_value_frac (i_value_frac),
        .i_pop        (pop),
        .o_head       (head)
    );

    // search engine
    rsa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_tolerance   (r_tolerance),
        .i_iter_limit  (r_iter_limit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator)
    );

endmodule

### sv/rsa_checker.sv
// rsa_checker: port-level checks on the rational approximation search
// depends on rsa_pkg; bound to rational_approximation_search
`timescale 1ns / 1ps

module rsa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_found,
    input logic [rsa_pkg::NUM_W-1:0]    o_numerator,
    input logic [rsa_pkg::DEN_W-1:0]    o_denominator
);
    import rsa_pkg::*;

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found)
            && $stable(o_numerator) && $stable(o_denominator))
        else $error("stalled result changed");

    // a miss carries zero numerator and denominator
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_numerator == '0 && o_denominator == '0)
        else $error("miss with nonzero fraction");

    // a hit never has a zero denominator
    a_hit_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_denominator != '0)
        else $error("hit with zero denominator");

endmodule

bind rational_approximation_search rsa_checker u_rsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_found       (o_found),
    .o_numerator   (o_numerator),
    .o_denominator (o_denominator)
);
